/* rtl/rkes_pkg.sv */
// ----------------------------------------------------------------------------
// rkes_pkg
// Shared sizes for the record key exchange sort unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rkes_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int KEY_W     = 16;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [KEY_W-1:0] t_key;

endpackage

`default_nettype wire

/* rtl/rkes_if.sv */
// ----------------------------------------------------------------------------
// rkes_in_if / rkes_out_if
// Valid/ready channels for keys going in and sorted keys coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rkes_in_if import rkes_pkg::*;;
    logic valid;
    logic ready;
    t_key age_key;
    logic last_item;

    modport source (output valid, output age_key, output last_item, input ready);
    modport sink   (input valid, input age_key, input last_item, output ready);
endinterface

interface rkes_out_if import rkes_pkg::*;;
    logic valid;
    logic ready;
    t_key sorted_key;
    logic last_out;

    modport source (output valid, output sorted_key, output last_out, input ready);
    modport sink   (input valid, input sorted_key, input last_out, output ready);
endinterface

`default_nettype wire

/* rtl/rkes_ram.sv */
// ----------------------------------------------------------------------------
// rkes_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rkes_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  wire logic [WIDTH-1:0]          i_wr_data,
    input  wire logic                      i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic      [WIDTH-1:0]          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/record_key_exchange_sort_unit.sv */
// ----------------------------------------------------------------------------
// record_key_exchange_sort_unit
// Sorts a run of signed 16-bit keys into ascending order.
// ----------------------------------------------------------------------------
// Keys enter on i_in, one word each; the word with last_item set closes the
// run. Each key is inserted into a key RAM kept in ascending order: the
// entries above the key's place move up one slot per cycle (read, compare,
// write back). A key into an empty store is written directly; any
// other key first reads the top held key, then each larger held key moves up
// and the new key fills the freed slot. Keys arriving while MAX_ITEMS are held
// are dropped; a dropped word marked last still closes the run. After the
// run closes, the held keys leave on o_out in ascending order, last_out on
// the final one; each word is read from the RAM and then loaded into the
// output register. i_in is not ready while a key is being inserted or the
// run is being emitted. A stall on o_out holds the output register and
// pauses the readout; once the final word sits in the output register the
// unit takes the next run's keys. Reset empties the store and drops any
// pending output; RAM contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module record_key_exchange_sort_unit import rkes_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rkes_in_if.sink      i_in,
    rkes_out_if.source   o_out
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SHIFT   = 3'd1;
    localparam logic [2:0] S_PLACE   = 3'd2;
    localparam logic [2:0] S_EMIT_RD = 3'd3;
    localparam logic [2:0] S_EMIT_LD = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ADDR_W-1:0] r_idx, n_idx;
    t_key             r_key, n_key;
    logic             r_last, n_last;
    logic             r_out_valid, n_out_valid;
    t_key             r_out_key, n_out_key;
    logic             r_out_last, n_out_last;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_key              ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;
    t_key              rd_key;
    logic              in_fire;
    logic              is_final;

    rkes_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ITEMS)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign rd_key       = t_key'(ram_rdata);
    assign i_in.ready   = (r_state == S_IDLE);
    assign in_fire      = i_in.valid && i_in.ready;
    assign is_final     = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));

    assign o_out.valid      = r_out_valid;
    assign o_out.sorted_key = r_out_key;
    assign o_out.last_out   = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_key   = r_out_key;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = r_key;
        ram_re      = 1'b0;
        ram_raddr   = r_idx;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_key  = i_in.age_key;
                    n_last = i_in.last_item;
                    if (r_count == CNT_W'(MAX_ITEMS)) begin
                        // store full: drop the key, still honor last
                        if (i_in.last_item) begin
                            n_idx   = '0;
                            n_state = S_EMIT_RD;
                        end
                    end else if (r_count == '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = i_in.age_key;
                        n_count   = CNT_W'(1);
                        if (i_in.last_item) begin
                            n_idx   = '0;
                            n_state = S_EMIT_RD;
                        end
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_count[ADDR_W-1:0] - ADDR_W'(1);
                        n_idx     = r_count[ADDR_W-1:0];
                        n_state   = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                ram_we = 1'b1;
                if (rd_key > r_key) begin
                    // move the larger entry up one slot
                    ram_waddr = r_idx;
                    ram_wdata = rd_key;
                    n_idx     = r_idx - ADDR_W'(1);
                    if (r_idx == ADDR_W'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx - ADDR_W'(2);
                    end
                end else begin
                    ram_waddr = r_idx;
                    ram_wdata = r_key;
                    n_count   = r_count + CNT_W'(1);
                    n_idx     = '0;
                    n_state   = r_last ? S_EMIT_RD : S_IDLE;
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = r_key;
                n_count   = r_count + CNT_W'(1);
                n_idx     = '0;
                n_state   = r_last ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                // read only when the output register is empty or frees up this cycle
                if (!r_out_valid || o_out.ready) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx;
                    n_state   = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                n_out_valid = 1'b1;
                n_out_key   = rd_key;
                n_out_last  = is_final;
                if (is_final) begin
                    n_count = '0;
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + ADDR_W'(1);
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_key      <= n_key;
        r_last     <= n_last;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
    end

endmodule

`default_nettype wire
